[hdl/cpe_pkg.sv]
// ----------------------------------------------------------------------------
// cpe_pkg
// Types and constants shared by the critical path engine.
// ----------------------------------------------------------------------------
`default_nettype none

package cpe_pkg;

  // request codes
  typedef enum logic [2:0] {
    REQ_LOAD       = 3'd0,
    REQ_COMPUTE    = 3'd1,
    REQ_READ_ORDER = 3'd2,
    REQ_READ_EDGE  = 3'd3,
    REQ_CLEAR      = 3'd4
  } req_t;

  // result status codes
  typedef enum logic [1:0] {
    STAT_OK           = 2'd0,
    STAT_CYCLE        = 2'd1,
    STAT_BAD          = 2'd2,
    STAT_NOT_COMPUTED = 2'd3
  } status_t;

  // outcome of the last compute
  typedef enum logic [1:0] {
    CS_NONE,
    CS_OK,
    CS_CYCLE
  } comp_state_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_CLR,
    S_LD_WR,
    S_RO_TOPO,
    S_RO_TIME,
    S_RE,
    S_CI_RD,
    S_CI_WR,
    S_SCAN,
    S_PICK,
    S_ROW_RD,
    S_ROW_WR,
    S_LI_RD,
    S_LI_E,
    S_LI_WR,
    S_RT_TOPO,
    S_RT_V,
    S_RT_LV,
    S_RV_RD,
    S_RV_WR,
    S_CR_EU,
    S_CR_E,
    S_CR_RD,
    S_CR_WR,
    S_FIN_RD,
    S_FIN
  } state_t;

  localparam int TIME_W   = 31;
  localparam int LATEST_W = 33;
  localparam int CFG_W    = 7;

  localparam logic [TIME_W-1:0]   TIME_MAX    = 31'h7FFF_FFFF;
  localparam logic [LATEST_W-1:0] LATEST_INIT = 33'h0_7F7F_7F7F;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [5:0]  src_node;
    logic [5:0]  dst_node;
    logic [15:0] weight;
    logic [5:0]  order_index;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [5:0]        node_id;
    logic [TIME_W-1:0] earliest_time;
    logic [TIME_W-1:0] latest_time;
    logic              critical_flag;
  } out_item_t;

endpackage

`default_nettype wire

[hdl/cpe_ram.sv]
// ----------------------------------------------------------------------------
// cpe_ram
// Single-port synchronous memory, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module cpe_ram #(
  parameter int AW = 6,
  parameter int DW = 8
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] addr,
  input  wire logic [DW-1:0] wdata,
  output logic      [DW-1:0] rdata
);

  logic [DW-1:0] mem_r [2**AW];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    rdata_r <= mem_r[addr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

[hdl/critical_path_engine.sv]
// ----------------------------------------------------------------------------
// critical_path_engine
// Critical path analysis of an activity-on-edge network held in on-chip RAM.
// ----------------------------------------------------------------------------
// Edges live in an N x N weight RAM (one critical bit per entry), node data in
// small per-node RAMs; one sequencer reads, modifies and writes them back, one
// item at a time. An edge load reads and then writes the entry; an order read
// steps through S_RO_TOPO and S_RO_TIME, an edge read through S_RE. Clear, a
// node_count write and reset sweep the edge RAM one entry a cycle over all
// 2**(2*clog2(MAX_NODES)) entries (4096 at 64 nodes), no item accepted meanwhile.
// Compute runs a setup pass, the ordering (a ready scan from node 0 plus a
// read and write per row entry), the backward pass and the marking pass.
// A result waits in an output register while the next item is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module critical_path_engine #(
  parameter int MAX_NODES    = 64,
  parameter int WEIGHT_WIDTH = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire cpe_pkg::in_item_t     in_data,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output cpe_pkg::out_item_t         out_data,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [cpe_pkg::CFG_W-1:0] cfg_data
);

  localparam int NW   = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int CW   = $clog2(MAX_NODES + 1);
  localparam int EAW  = 2 * NW;
  localparam int WW   = WEIGHT_WIDTH;
  localparam int TW   = cpe_pkg::TIME_W;
  localparam int LW   = cpe_pkg::LATEST_W;
  localparam int NRST = (MAX_NODES < 64) ? MAX_NODES : 64;

  function automatic logic [TW-1:0] clamp_lt(input logic [LW-1:0] l);
    clamp_lt = l[LW-1] ? '0 : l[TW-1:0];
  endfunction

  // registers
  cpe_pkg::state_t      st_r, st_nxt;
  cpe_pkg::comp_state_t cs_r, cs_nxt;
  cpe_pkg::in_item_t    req_r, req_nxt;
  cpe_pkg::out_item_t   res_r, res_nxt, out_data_r, out_data_nxt;
  logic                 pend_r, pend_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [EAW-1:0]       clr_r, clr_nxt;
  logic [CW-1:0]        n_r, n_nxt;
  logic [CW-1:0]        x_r, x_nxt;
  logic [CW-1:0]        y_r, y_nxt;
  logic [CW-1:0]        cnt_r, cnt_nxt;
  logic [NW-1:0]        u_r, u_nxt;
  logic [NW-1:0]        v_r, v_nxt;
  logic [TW-1:0]        eu_r, eu_nxt;
  logic [LW-1:0]        lv_r, lv_nxt;
  logic [MAX_NODES-1:0] ready_r, ready_nxt;

  // memory ports
  logic           e_we;
  logic [EAW-1:0] e_addr;
  logic [WW:0]    e_wd, e_rd;
  logic           id_we;
  logic [NW-1:0]  id_addr;
  logic [CW-1:0]  id_wd, id_rd;
  logic           wk_we;
  logic [NW-1:0]  wk_addr;
  logic [CW-1:0]  wk_wd, wk_rd;
  logic           er_we;
  logic [NW-1:0]  er_addr;
  logic [TW-1:0]  er_wd, er_rd;
  logic           la_we;
  logic [NW-1:0]  la_addr;
  logic [LW-1:0]  la_wd, la_rd;
  logic           tp_we;
  logic [NW-1:0]  tp_addr;
  logic [NW-1:0]  tp_wd, tp_rd;

  cpe_ram #(.AW(EAW), .DW(WW + 1)) u_edge (
    .clk(clk), .we(e_we), .addr(e_addr), .wdata(e_wd), .rdata(e_rd)
  );
  cpe_ram #(.AW(NW), .DW(CW)) u_indeg (
    .clk(clk), .we(id_we), .addr(id_addr), .wdata(id_wd), .rdata(id_rd)
  );
  cpe_ram #(.AW(NW), .DW(CW)) u_work (
    .clk(clk), .we(wk_we), .addr(wk_addr), .wdata(wk_wd), .rdata(wk_rd)
  );
  cpe_ram #(.AW(NW), .DW(TW)) u_earliest (
    .clk(clk), .we(er_we), .addr(er_addr), .wdata(er_wd), .rdata(er_rd)
  );
  cpe_ram #(.AW(NW), .DW(LW)) u_latest (
    .clk(clk), .we(la_we), .addr(la_addr), .wdata(la_wd), .rdata(la_rd)
  );
  cpe_ram #(.AW(NW), .DW(NW)) u_topo (
    .clk(clk), .we(tp_we), .addr(tp_addr), .wdata(tp_wd), .rdata(tp_rd)
  );

  always_comb begin
    logic [NW-1:0] xi;
    logic [NW-1:0] yi;
    logic [NW-1:0] nm1;
    logic [WW-1:0] w;
    logic [CW-1:0] wd;
    logic [31:0]   sum;
    logic [TW-1:0] t;
    logic [LW-1:0] ld;
    logic          last_x;
    logic [cpe_pkg::CFG_W-1:0] cv;

    xi     = x_r[NW-1:0];
    yi     = y_r[NW-1:0];
    nm1    = NW'(n_r - CW'(1));
    w      = e_rd[WW-1:0];
    wd     = '0;
    sum    = '0;
    t      = '0;
    ld     = '0;
    last_x = (x_r + CW'(1) == n_r);
    cv     = cfg_data;

    st_nxt    = st_r;
    cs_nxt    = cs_r;
    req_nxt   = req_r;
    res_nxt   = res_r;
    pend_nxt  = pend_r;
    clr_nxt   = clr_r;
    n_nxt     = n_r;
    x_nxt     = x_r;
    y_nxt     = y_r;
    cnt_nxt   = cnt_r;
    u_nxt     = u_r;
    v_nxt     = v_r;
    eu_nxt    = eu_r;
    lv_nxt    = lv_r;
    ready_nxt = ready_r;

    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (pend_r && (!out_valid_r || out_ready)) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = res_r;
      pend_nxt      = 1'b0;
    end

    e_we = 1'b0;  e_addr = '0;  e_wd = '0;
    id_we = 1'b0; id_addr = '0; id_wd = '0;
    wk_we = 1'b0; wk_addr = '0; wk_wd = '0;
    er_we = 1'b0; er_addr = '0; er_wd = '0;
    la_we = 1'b0; la_addr = '0; la_wd = '0;
    tp_we = 1'b0; tp_addr = '0; tp_wd = '0;

    // a node count write has priority over an item in the same cycle
    in_ready = (st_r == cpe_pkg::S_IDLE) && !pend_r && !cfg_valid;

    unique case (st_r)
      cpe_pkg::S_IDLE: begin
        if (in_valid && in_ready) begin
          req_nxt = in_data;
          res_nxt = '0;
          unique case (in_data.req_type)
            cpe_pkg::REQ_LOAD: begin
              if (32'(in_data.src_node) >= 32'(n_r) || 32'(in_data.dst_node) >= 32'(n_r)
                  || WW'(in_data.weight) == '0) begin
                res_nxt.status = cpe_pkg::STAT_BAD;
                pend_nxt       = 1'b1;
              end else begin
                e_addr  = {NW'(in_data.src_node), NW'(in_data.dst_node)};
                id_addr = NW'(in_data.dst_node);
                st_nxt  = cpe_pkg::S_LD_WR;
              end
            end
            cpe_pkg::REQ_COMPUTE: begin
              ready_nxt = '0;
              x_nxt     = '0;
              st_nxt    = cpe_pkg::S_CI_RD;
            end
            cpe_pkg::REQ_READ_ORDER: begin
              if (cs_r == cpe_pkg::CS_NONE) begin
                res_nxt.status = cpe_pkg::STAT_NOT_COMPUTED;
                pend_nxt       = 1'b1;
              end else if (cs_r == cpe_pkg::CS_CYCLE) begin
                res_nxt.status = cpe_pkg::STAT_CYCLE;
                pend_nxt       = 1'b1;
              end else if (32'(in_data.order_index) >= 32'(n_r)) begin
                res_nxt.status = cpe_pkg::STAT_BAD;
                pend_nxt       = 1'b1;
              end else begin
                tp_addr = NW'(in_data.order_index);
                st_nxt  = cpe_pkg::S_RO_TOPO;
              end
            end
            cpe_pkg::REQ_READ_EDGE: begin
              if (cs_r == cpe_pkg::CS_NONE) begin
                res_nxt.status = cpe_pkg::STAT_NOT_COMPUTED;
                pend_nxt       = 1'b1;
              end else if (cs_r == cpe_pkg::CS_CYCLE) begin
                res_nxt.status = cpe_pkg::STAT_CYCLE;
                pend_nxt       = 1'b1;
              end else if (32'(in_data.src_node) >= 32'(n_r)
                           || 32'(in_data.dst_node) >= 32'(n_r)) begin
                res_nxt.status = cpe_pkg::STAT_BAD;
                pend_nxt       = 1'b1;
              end else begin
                e_addr = {NW'(in_data.src_node), NW'(in_data.dst_node)};
                st_nxt = cpe_pkg::S_RE;
              end
            end
            cpe_pkg::REQ_CLEAR: begin
              cs_nxt   = cpe_pkg::CS_NONE;
              pend_nxt = 1'b1;
              clr_nxt  = '0;
              st_nxt   = cpe_pkg::S_CLR;
            end
            default: begin
              res_nxt.status = cpe_pkg::STAT_BAD;
              pend_nxt       = 1'b1;
            end
          endcase
        end
      end

      // wipe edge weights, and in-degrees during the first row
      cpe_pkg::S_CLR: begin
        e_we    = 1'b1;
        e_addr  = clr_r;
        id_we   = (clr_r[EAW-1:NW] == '0);
        id_addr = clr_r[NW-1:0];
        clr_nxt = clr_r + EAW'(1);
        if (&clr_r) begin
          st_nxt = cpe_pkg::S_IDLE;
        end
      end

      cpe_pkg::S_LD_WR: begin
        e_we   = 1'b1;
        e_addr = {NW'(req_r.src_node), NW'(req_r.dst_node)};
        e_wd   = {1'b0, WW'(req_r.weight)};
        if (w == '0) begin
          id_we   = 1'b1;
          id_addr = NW'(req_r.dst_node);
          id_wd   = id_rd + CW'(1);
        end
        cs_nxt   = cpe_pkg::CS_NONE;
        pend_nxt = 1'b1;
        st_nxt   = cpe_pkg::S_IDLE;
      end

      cpe_pkg::S_RO_TOPO: begin
        v_nxt   = tp_rd;
        er_addr = tp_rd;
        la_addr = tp_rd;
        st_nxt  = cpe_pkg::S_RO_TIME;
      end

      cpe_pkg::S_RO_TIME: begin
        res_nxt.node_id       = 6'(v_r);
        res_nxt.earliest_time = er_rd;
        res_nxt.latest_time   = clamp_lt(la_rd);
        pend_nxt              = 1'b1;
        st_nxt                = cpe_pkg::S_IDLE;
      end

      cpe_pkg::S_RE: begin
        res_nxt.critical_flag = e_rd[WW];
        pend_nxt              = 1'b1;
        st_nxt                = cpe_pkg::S_IDLE;
      end

      // working in-degrees, zero earliest times, initial ready set
      cpe_pkg::S_CI_RD: begin
        id_addr = xi;
        st_nxt  = cpe_pkg::S_CI_WR;
      end

      cpe_pkg::S_CI_WR: begin
        wk_we         = 1'b1;
        wk_addr       = xi;
        wk_wd         = id_rd;
        er_we         = 1'b1;
        er_addr       = xi;
        ready_nxt[xi] = (id_rd == '0);
        if (last_x) begin
          x_nxt   = '0;
          cnt_nxt = '0;
          st_nxt  = cpe_pkg::S_SCAN;
        end else begin
          x_nxt  = x_r + CW'(1);
          st_nxt = cpe_pkg::S_CI_RD;
        end
      end

      // lowest-numbered ready node first
      cpe_pkg::S_SCAN: begin
        if (ready_r[xi]) begin
          ready_nxt[xi] = 1'b0;
          u_nxt         = xi;
          tp_we         = 1'b1;
          tp_addr       = cnt_r[NW-1:0];
          tp_wd         = xi;
          cnt_nxt       = cnt_r + CW'(1);
          er_addr       = xi;
          st_nxt        = cpe_pkg::S_PICK;
        end else if (last_x) begin
          if (cnt_r == n_r) begin
            st_nxt = cpe_pkg::S_LI_RD;
          end else begin
            cs_nxt         = cpe_pkg::CS_CYCLE;
            res_nxt.status = cpe_pkg::STAT_CYCLE;
            pend_nxt       = 1'b1;
            st_nxt         = cpe_pkg::S_IDLE;
          end
        end else begin
          x_nxt = x_r + CW'(1);
        end
      end

      cpe_pkg::S_PICK: begin
        eu_nxt = er_rd;
        x_nxt  = '0;
        st_nxt = cpe_pkg::S_ROW_RD;
      end

      cpe_pkg::S_ROW_RD: begin
        e_addr  = {u_r, xi};
        wk_addr = xi;
        er_addr = xi;
        st_nxt  = cpe_pkg::S_ROW_WR;
      end

      cpe_pkg::S_ROW_WR: begin
        if (w != '0) begin
          wd      = (wk_rd != '0) ? wk_rd - CW'(1) : '0;
          wk_we   = 1'b1;
          wk_addr = xi;
          wk_wd   = wd;
          if (wd == '0) begin
            ready_nxt[xi] = 1'b1;
          end
          sum = {1'b0, eu_r} + 32'(w);
          t   = sum[31] ? cpe_pkg::TIME_MAX : sum[TW-1:0];
          if (t > er_rd) begin
            er_we   = 1'b1;
            er_addr = xi;
            er_wd   = t;
          end
        end
        if (last_x) begin
          x_nxt  = '0;
          st_nxt = cpe_pkg::S_SCAN;
        end else begin
          x_nxt  = x_r + CW'(1);
          st_nxt = cpe_pkg::S_ROW_RD;
        end
      end

      cpe_pkg::S_LI_RD: begin
        er_addr = nm1;
        st_nxt  = cpe_pkg::S_LI_E;
      end

      cpe_pkg::S_LI_E: begin
        lv_nxt = LW'(er_rd);
        x_nxt  = '0;
        st_nxt = cpe_pkg::S_LI_WR;
      end

      cpe_pkg::S_LI_WR: begin
        la_we   = 1'b1;
        la_addr = xi;
        la_wd   = last_x ? lv_r : cpe_pkg::LATEST_INIT;
        if (last_x) begin
          y_nxt  = n_r - CW'(1);
          st_nxt = cpe_pkg::S_RT_TOPO;
        end else begin
          x_nxt = x_r + CW'(1);
        end
      end

      // backward pass in reverse order
      cpe_pkg::S_RT_TOPO: begin
        tp_addr = yi;
        st_nxt  = cpe_pkg::S_RT_V;
      end

      cpe_pkg::S_RT_V: begin
        v_nxt   = tp_rd;
        la_addr = tp_rd;
        st_nxt  = cpe_pkg::S_RT_LV;
      end

      cpe_pkg::S_RT_LV: begin
        lv_nxt = la_rd;
        x_nxt  = '0;
        st_nxt = cpe_pkg::S_RV_RD;
      end

      cpe_pkg::S_RV_RD: begin
        e_addr  = {xi, v_r};
        la_addr = xi;
        st_nxt  = cpe_pkg::S_RV_WR;
      end

      cpe_pkg::S_RV_WR: begin
        ld = lv_r - LW'(w);
        if (w != '0 && $signed(ld) < $signed(la_rd)) begin
          la_we   = 1'b1;
          la_addr = xi;
          la_wd   = ld;
        end
        if (last_x) begin
          if (y_r == '0) begin
            st_nxt = cpe_pkg::S_CR_EU;
          end else begin
            y_nxt  = y_r - CW'(1);
            st_nxt = cpe_pkg::S_RT_TOPO;
          end
        end else begin
          x_nxt  = x_r + CW'(1);
          st_nxt = cpe_pkg::S_RV_RD;
        end
      end

      // zero-slack marking, row by row
      cpe_pkg::S_CR_EU: begin
        er_addr = yi;
        st_nxt  = cpe_pkg::S_CR_E;
      end

      cpe_pkg::S_CR_E: begin
        eu_nxt = er_rd;
        x_nxt  = '0;
        st_nxt = cpe_pkg::S_CR_RD;
      end

      cpe_pkg::S_CR_RD: begin
        e_addr  = {yi, xi};
        la_addr = xi;
        st_nxt  = cpe_pkg::S_CR_WR;
      end

      cpe_pkg::S_CR_WR: begin
        ld     = la_rd - LW'(w);
        e_we   = 1'b1;
        e_addr = {yi, xi};
        e_wd   = {(w != '0) && (LW'(eu_r) == ld), w};
        if (last_x) begin
          if (y_r + CW'(1) == n_r) begin
            st_nxt = cpe_pkg::S_FIN_RD;
          end else begin
            y_nxt  = y_r + CW'(1);
            st_nxt = cpe_pkg::S_CR_EU;
          end
        end else begin
          x_nxt  = x_r + CW'(1);
          st_nxt = cpe_pkg::S_CR_RD;
        end
      end

      cpe_pkg::S_FIN_RD: begin
        er_addr = nm1;
        la_addr = nm1;
        st_nxt  = cpe_pkg::S_FIN;
      end

      cpe_pkg::S_FIN: begin
        cs_nxt                = cpe_pkg::CS_OK;
        res_nxt.node_id       = 6'(nm1);
        res_nxt.earliest_time = er_rd;
        res_nxt.latest_time   = clamp_lt(la_rd);
        pend_nxt              = 1'b1;
        st_nxt                = cpe_pkg::S_IDLE;
      end

      default: begin
        st_nxt = cpe_pkg::S_IDLE;
      end
    endcase

    // node count write also clears the graph
    if (cfg_valid && cfg_ready) begin
      if (cv == '0) begin
        n_nxt = CW'(1);
      end else if (32'(cv) > 32'(MAX_NODES)) begin
        n_nxt = CW'(MAX_NODES);
      end else begin
        n_nxt = CW'(cv);
      end
      cs_nxt  = cpe_pkg::CS_NONE;
      clr_nxt = '0;
      st_nxt  = cpe_pkg::S_CLR;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= cpe_pkg::S_CLR;
      cs_r        <= cpe_pkg::CS_NONE;
      clr_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
      n_r         <= CW'(NRST);
      x_r         <= '0;
      y_r         <= '0;
      cnt_r       <= '0;
      ready_r     <= '0;
    end else begin
      st_r        <= st_nxt;
      cs_r        <= cs_nxt;
      clr_r       <= clr_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
      n_r         <= n_nxt;
      x_r         <= x_nxt;
      y_r         <= y_nxt;
      cnt_r       <= cnt_nxt;
      ready_r     <= ready_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
    u_r        <= u_nxt;
    v_r        <= v_nxt;
    eu_r       <= eu_nxt;
    lv_r       <= lv_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  // node count is taken only with nothing in flight
  assign cfg_ready = (st_r == cpe_pkg::S_IDLE) && !pend_r;

  // a waiting result is neither dropped nor changed
  assert property (@(posedge clk) disable iff (!rst_n)
    pend_r && out_valid_r && !out_ready |=> pend_r && $stable(res_r))
    else $error("pending result lost");

  // one item in flight
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken while busy");

  // ordering never places more nodes than are in use
  assert property (@(posedge clk) disable iff (!rst_n)
    st_r == cpe_pkg::S_SCAN |-> cnt_r <= n_r)
    else $error("order count overrun");

endmodule

`default_nettype wire
